### hw/rtl/lepct_pkg.sv
// Types, constants and AES round functions shared by the pairing crypto toolbox.
`default_nettype none
package lepct_pkg;

  typedef enum logic [1:0] {
    OP_E   = 2'd0,
    OP_C1  = 2'd1,
    OP_S1  = 2'd2,
    OP_RSV = 2'd3
  } lepct_op_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [55:0] request_command;
    logic [55:0] response_command;
    logic [7:0]  init_addr_type;
    logic [47:0] init_address;
    logic [7:0]  resp_addr_type;
    logic [47:0] resp_address;
  } lepct_in_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
  } lepct_out_t;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned NumRounds  = 10;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Block byte 0 sits in the most significant octet of the word.
  function automatic logic [127:0] shift_mix(input logic [127:0] s, input logic last);
    logic [7:0]   b [16];
    logic [7:0]   t [16];
    logic [7:0]   all;
    logic [127:0] r;
    for (int j = 0; j < 16; j++) begin
      b[j] = s[127-8*j -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        t[4*c+w] = b[4*((c+w)%4)+w];
      end
    end
    r = '0;
    for (int c = 0; c < 4; c++) begin
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      for (int w = 0; w < 4; w++) begin
        if (last) begin
          r[127-8*(4*c+w) -: 8] = t[4*c+w];
        end else begin
          r[127-8*(4*c+w) -: 8] = t[4*c+w] ^ all ^ gf_double(t[4*c+w] ^ t[4*c+(w+1)%4]);
        end
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/le_pairing_crypto_toolbox.sv
// Top level of the pairing crypto toolbox: functions e, c1 and s1 over one AES core.
//
//   channel | direction | payload              | handshake
//   in      | input     | lepct_pkg::lepct_in_t  | in_valid_i / in_ready_o
//   out     | output    | lepct_pkg::lepct_out_t | out_valid_o / out_ready_i
//
// Each AES pass is a load step, then ten rounds of sixteen byte-serial S-box
// steps and one mix step, set by the single state S-box.
// A c1 item runs two AES passes, any other item one.
// Reset clears all control state at once; there is no clearing pass.
// A new item is taken while a finished result waits in the output register.
`default_nettype none
module le_pairing_crypto_toolbox (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire lepct_pkg::lepct_in_t  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output lepct_pkg::lepct_out_t      out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN1,
    S_RUN2,
    S_HOLD
  } top_state_e;

  top_state_e            state_q;
  logic                  c1_q;
  logic [127:0]          key_q;
  logic [127:0]          p2_q;
  logic [127:0]          res_q;
  logic                  out_valid_q;
  lepct_pkg::lepct_out_t out_q;

  logic         in_fire;
  logic         is_c1;
  logic [127:0] p1;
  logic [127:0] first_blk;
  logic         core_start;
  logic [127:0] core_key;
  logic [127:0] core_blk;
  logic         core_done;
  logic [127:0] core_out;
  logic         out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_c1      = (lepct_pkg::lepct_op_e'(in_data_i.op) == lepct_pkg::OP_C1);
  assign p1         = {in_data_i.response_command, in_data_i.request_command,
                       in_data_i.resp_addr_type, in_data_i.init_addr_type};
  assign first_blk  = {in_data_i.data_high, in_data_i.data_low} ^ (is_c1 ? p1 : '0);
  assign core_start = in_fire || (state_q == S_RUN1 && core_done && c1_q);
  assign core_key   = in_fire ? {in_data_i.key_high, in_data_i.key_low} : key_q;
  assign core_blk   = in_fire ? first_blk : (core_out ^ p2_q);
  assign out_free   = !out_valid_q || out_ready_i;

  lepct_aes u_aes (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(core_start),
    .key_i  (core_key),
    .blk_i  (core_blk),
    .done_o (core_done),
    .blk_o  (core_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      c1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            c1_q    <= is_c1;
            key_q   <= {in_data_i.key_high, in_data_i.key_low};
            p2_q    <= {32'd0, in_data_i.init_address, in_data_i.resp_address};
            state_q <= S_RUN1;
          end
        end
        S_RUN1: begin
          if (core_done) begin
            if (c1_q) begin
              state_q <= S_RUN2;
            end else begin
              res_q   <= core_out;
              state_q <= S_HOLD;
            end
          end
        end
        S_RUN2: begin
          if (core_done) begin
            res_q   <= core_out;
            state_q <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_q.result_low  <= res_q[63:0];
            out_q.result_high <= res_q[127:64];
            out_valid_q       <= 1'b1;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done |-> (state_q == S_RUN1 || state_q == S_RUN2))
    else $error("AES core finished outside a running pass");

  a_fire_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_RUN1)
    else $error("accepted item did not start a pass");

  a_second_pass_c1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN2 |-> c1_q)
    else $error("second AES pass for an item that is not c1");

  a_hold_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOLD && out_free) |=> out_valid_q)
    else $error("result not moved to the output register");

endmodule
`default_nettype wire

### hw/rtl/lepct_aes.sv
// Byte-serial AES-128 encryption core with an on-the-fly key schedule.
`default_nettype none
module lepct_aes (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [127:0] key_i,
  input  wire logic [127:0] blk_i,
  output logic              done_o,
  output logic [127:0]      blk_o
);

  typedef enum logic [1:0] {
    A_IDLE,
    A_SUB,
    A_MIX
  } aes_state_e;

  aes_state_e   state_q;
  logic [3:0]   cnt_q;
  logic [3:0]   round_q;
  logic [7:0]   rcon_q;
  logic [127:0] st_q;
  logic [127:0] rk_q;
  logic [31:0]  tw_q;
  logic         done_q;

  logic [1:0]   key_sel;
  logic [7:0]   key_byte;
  logic [31:0]  w0_d, w1_d, w2_d, w3_d;
  logic [127:0] rk_d;

  assign key_sel  = cnt_q[1:0] + 2'd1;
  assign key_byte = rk_q[31 - 8*key_sel -: 8];
  assign w0_d     = rk_q[127:96] ^ tw_q ^ {rcon_q, 24'd0};
  assign w1_d     = rk_q[95:64] ^ w0_d;
  assign w2_d     = rk_q[63:32] ^ w1_d;
  assign w3_d     = rk_q[31:0] ^ w2_d;
  assign rk_d     = {w0_d, w1_d, w2_d, w3_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
      round_q <= '0;
      rcon_q  <= 8'h01;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        A_IDLE: begin
          if (start_i) begin
            st_q    <= blk_i ^ key_i;
            rk_q    <= key_i;
            rcon_q  <= 8'h01;
            round_q <= 4'd1;
            cnt_q   <= '0;
            state_q <= A_SUB;
          end
        end
        A_SUB: begin
          st_q  <= {st_q[119:0], lepct_pkg::SBOX[st_q[127:120]]};
          if (cnt_q < 4'd4) begin
            tw_q <= {tw_q[23:0], lepct_pkg::SBOX[key_byte]};
          end
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'(lepct_pkg::BlockBytes - 1)) begin
            state_q <= A_MIX;
          end
        end
        A_MIX: begin
          st_q   <= lepct_pkg::shift_mix(st_q,
                      round_q == 4'(lepct_pkg::NumRounds)) ^ rk_d;
          rk_q   <= rk_d;
          rcon_q <= lepct_pkg::gf_double(rcon_q);
          cnt_q  <= '0;
          if (round_q == 4'(lepct_pkg::NumRounds)) begin
            done_q  <= 1'b1;
            state_q <= A_IDLE;
          end else begin
            round_q <= round_q + 4'd1;
            state_q <= A_SUB;
          end
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign blk_o  = st_q;

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the pairing crypto toolbox (functions e, c1 and s1).
`timescale 1ns / 1ps
module tb;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  lepct_pkg::lepct_in_t  in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  lepct_pkg::lepct_out_t out_data_o;

  le_pairing_crypto_toolbox DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  localparam int NumRandom = 1300;
  localparam int CycleLimit = 4000000;

  lepct_pkg::lepct_in_t  pending_items[$];
  lepct_pkg::lepct_out_t expected_results[$];
  int         mismatches = 0;
  bit         stimulus_done = 0;
  bit         calm = 0;
  int         in_gap = 0;
  int         out_stall = 0;
  int         cycles = 0;
  int         in_sent = 0;
  int         in_taken = 0;

  byte unsigned sbox_tbl [256];
  initial for (int i = 0; i < 256; i++) sbox_tbl[i] = lepct_pkg::SBOX[i];

  function automatic byte unsigned xtime(byte unsigned v);
    return byte'((v << 1) ^ (v[7] ? 8'h1b : 8'h00));
  endfunction

  // AES-128 with the integer's most significant octet as block byte 0.
  function automatic logic [127:0] aes128(logic [127:0] key, logic [127:0] blk);
    byte unsigned rk [176];
    byte unsigned st [16];
    byte unsigned tmp [16];
    byte unsigned t [4];
    byte unsigned f, all;
    byte unsigned rcon;
    logic [127:0] res;
    rcon = 8'h01;
    for (int j = 0; j < 16; j++) begin
      rk[j] = key[127-8*j -: 8];
      st[j] = blk[127-8*j -: 8];
    end
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) t[j] = rk[4*(i-1)+j];
      if (i % 4 == 0) begin
        f = t[0];
        t[0] = sbox_tbl[t[1]] ^ rcon;
        t[1] = sbox_tbl[t[2]];
        t[2] = sbox_tbl[t[3]];
        t[3] = sbox_tbl[f];
        rcon = xtime(rcon);
      end
      for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ t[j];
    end
    for (int j = 0; j < 16; j++) st[j] ^= rk[j];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) tmp[4*c+w] = sbox_tbl[st[4*((c+w)%4)+w]];
      for (int c = 0; c < 4; c++) begin
        all = tmp[4*c] ^ tmp[4*c+1] ^ tmp[4*c+2] ^ tmp[4*c+3];
        for (int w = 0; w < 4; w++) begin
          if (r == 10) st[4*c+w] = tmp[4*c+w];
          else st[4*c+w] = tmp[4*c+w] ^ all ^ xtime(tmp[4*c+w] ^ tmp[4*c+(w+1)%4]);
        end
      end
      for (int j = 0; j < 16; j++) st[j] ^= rk[16*r+j];
    end
    for (int j = 0; j < 16; j++) res[127-8*j -: 8] = st[j];
    return res;
  endfunction

  function automatic lepct_pkg::lepct_out_t pairing_result(lepct_pkg::lepct_in_t it);
    logic [127:0] key, val, p1, p2;
    lepct_pkg::lepct_out_t o;
    key = {it.key_high, it.key_low};
    val = {it.data_high, it.data_low};
    if (lepct_pkg::lepct_op_e'(it.op) == lepct_pkg::OP_C1) begin
      p1 = {it.response_command, it.request_command, it.resp_addr_type,
            it.init_addr_type};
      p2 = {32'h0, it.init_address, it.resp_address};
      val = aes128(key, aes128(key, val ^ p1) ^ p2);
    end else begin
      val = aes128(key, val);
    end
    o.result_high = val[127:64];
    o.result_low = val[63:0];
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic lepct_pkg::lepct_in_t random_item(lepct_pkg::lepct_op_e op);
    lepct_pkg::lepct_in_t it;
    it.op = op;
    it.key_low = rand64();
    it.key_high = rand64();
    it.data_low = rand64();
    it.data_high = rand64();
    it.request_command = 56'(rand64());
    it.response_command = 56'(rand64());
    it.init_addr_type = 8'($urandom());
    it.init_address = 48'(rand64());
    it.resp_addr_type = 8'($urandom());
    it.resp_address = 48'(rand64());
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  initial begin
    lepct_pkg::lepct_in_t it;
    it = '0;
    it.op = lepct_pkg::OP_E;
    pending_items.push_back(it);
    it = '1;
    it.op = lepct_pkg::OP_E;
    pending_items.push_back(it);
    // Standard AES-128 example vector.
    it = '0;
    it.op = lepct_pkg::OP_E;
    it.key_high = 64'h0001020304050607;
    it.key_low = 64'h08090a0b0c0d0e0f;
    it.data_high = 64'h0011223344556677;
    it.data_low = 64'h8899aabbccddeeff;
    pending_items.push_back(it);
    // Confirm value example from the core specification.
    it = '0;
    it.op = lepct_pkg::OP_C1;
    it.data_high = 64'h5783d52156ad6f0e;
    it.data_low = 64'h6388274ec6702ee0;
    it.request_command = 56'h07071000000101;
    it.response_command = 56'h05000800000302;
    it.init_addr_type = 8'h01;
    it.resp_addr_type = 8'h00;
    it.init_address = 48'ha1a2a3a4a5a6;
    it.resp_address = 48'hb1b2b3b4b5b6;
    pending_items.push_back(it);
    it = '0;
    it.op = lepct_pkg::OP_C1;
    pending_items.push_back(it);
    it = '1;
    it.op = lepct_pkg::OP_C1;
    pending_items.push_back(it);
    it = '0;
    it.op = lepct_pkg::OP_S1;
    it.data_high = 64'h000f0e0d0c0b0a09;
    it.data_low = 64'h0807060504030201;
    pending_items.push_back(it);
    it = '1;
    it.op = lepct_pkg::OP_S1;
    pending_items.push_back(it);
    it = '1;
    it.op = lepct_pkg::OP_RSV;
    pending_items.push_back(it);
    for (int i = 0; i < 12; i++) begin
      pending_items.push_back(random_item(lepct_pkg::lepct_op_e'(i % 4)));
    end
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom - 150) calm = 1;
      pending_items.push_back(random_item(lepct_pkg::lepct_op_e'($urandom_range(0, 3))));
      while (pending_items.size() > 4) @(posedge clk_i);
    end
    while (pending_items.size() != 0 || in_valid_i) @(posedge clk_i);
    stimulus_done = 1;
  end

  // Driver.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_sent == in_taken) begin
        in_valid_i <= 1'b0;
      end else if (!in_valid_i) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (pending_items.size() != 0) begin
          if (!calm && $urandom_range(0, 3) == 0) begin
            in_gap <= $urandom_range(0, 16);
          end else begin
            in_data_i <= pending_items.pop_front();
            in_valid_i <= 1'b1;
            in_sent <= in_sent + 1;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= $urandom_range(0, 16);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    lepct_pkg::lepct_out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(pairing_result(in_data_i));
        in_taken <= in_taken + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result_low", out_data_o.result_low, 64'h0);
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.result_low !== want.result_low)
            report_mismatch("result_low", out_data_o.result_low, want.result_low);
          if (out_data_o.result_high !== want.result_high)
            report_mismatch("result_high", out_data_o.result_high, want.result_high);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (stimulus_done);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### le_pairing_crypto_toolbox.f
hw/rtl/lepct_pkg.sv
hw/rtl/lepct_aes.sv
hw/rtl/le_pairing_crypto_toolbox.sv
tb/tb.sv
